/* rtl/kdes_pkg.sv */
`default_nettype none

package kdes_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_KEY     = 2'd0;
    localparam logic [1:0] OP_SCROLL  = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    // Key codes with a special meaning.
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd8;
    localparam logic [3:0] KEY_STAR       = 4'd9;
    localparam logic [3:0] KEY_ZERO       = 4'd10;
    localparam logic [3:0] KEY_TOGGLE     = 4'd11;

    // Active-low segment byte of a dark position.
    localparam logic [7:0] BLANK = 8'hFF;

    // Widest display position address (up to eight positions).
    localparam int POS_W = 3;

    // Command bundle for the display memory.
    typedef struct packed {
        logic             clr;
        logic             we;
        logic [POS_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [POS_W-1:0] raddr;
    } t_disp_cmd;

    // Key code to active-low segment byte.
    function automatic logic [7:0] seg_code(input logic [3:0] key);
        logic [7:0] code;
        case (key)
            4'd0:    code = 8'hF9;
            4'd1:    code = 8'hA4;
            4'd2:    code = 8'hB0;
            4'd3:    code = 8'h99;
            4'd4:    code = 8'h92;
            4'd5:    code = 8'h82;
            4'd6:    code = 8'hF8;
            4'd7:    code = 8'h80;
            4'd8:    code = 8'h90;
            4'd10:   code = 8'hC0;
            default: code = BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/kdes_disp.sv */
`default_nettype none

// Display byte memory with one valid bit per position; an invalid
// position reads as blank. Read data is registered.
module kdes_disp #(
    parameter int NUM_POSITIONS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kdes_pkg::t_disp_cmd i_cmd,
    output logic [7:0]             o_rdata
);

    localparam int PW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;

    logic [7:0]               r_mem [NUM_POSITIONS];
    logic [NUM_POSITIONS-1:0] r_vld;
    logic [7:0]               r_q;

    // Valid bits: cleared by reset or a clear command, set on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.we) begin
            r_vld[i_cmd.waddr[PW-1:0]] <= 1'b1;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr[PW-1:0]] <= i_cmd.wdata;
        end
        r_q <= r_vld[i_cmd.raddr[PW-1:0]] ? r_mem[i_cmd.raddr[PW-1:0]] : kdes_pkg::BLANK;
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* rtl/keypad_digit_entry_scroll_display.sv */
// A key press, an ignored scroll tick or an unused op is answered from S_EXEC; a refresh
// tick passes S_EXEC and S_REF_OUT, and a scroll tick passes S_EXEC and then S_SCR_RD and
// S_SCR_WR for each display position. One transaction is taken at a time (o_ready only in
// S_IDLE), and a result waits while the output register holds an unaccepted one.
// Reset (synchronous, active low) clears control state and marks all display
// positions blank through their valid bits; the digit store is not cleared.
`default_nettype none

module keypad_digit_entry_scroll_display #(
    parameter int MAX_DIGITS    = 10,
    parameter int NUM_POSITIONS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [3:0] i_key,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_segments,
    output logic [7:0]      o_digit_select,
    output logic            o_entry_mode,
    output logic [3:0]      o_digit_count
);

    localparam int PW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int SW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_POSITIONS - 1);
    localparam logic [PW:0]   NP_W     = (PW + 1)'(NUM_POSITIONS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCR_RD  = 3'd2;
    localparam logic [2:0] S_SCR_WR  = 3'd3;
    localparam logic [2:0] S_REF_OUT = 3'd4;

    // Control registers.
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_op;
    logic [3:0]    r_key;
    logic          r_entering, n_entering;
    logic          r_scr_en, n_scr_en;
    logic [3:0]    r_count, n_count;
    logic [3:0]    r_ring, n_ring;
    logic [3:0]    r_pos, n_pos;
    logic          r_back, n_back;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_prp, n_prp;
    logic [PW-1:0] r_base, n_base;
    logic [PW-1:0] r_i, n_i;
    logic [3:0]    r_idx, n_idx;
    logic          r_hit, n_hit;

    // Output register.
    logic          r_ov;
    logic [7:0]    r_seg, n_seg;
    logic [7:0]    r_sel, n_sel;
    logic          emit;

    // Digit store.
    logic [3:0]    r_store [MAX_DIGITS];
    logic [3:0]    r_st_q;
    logic          st_we;
    logic [SW-1:0] st_raddr;

    kdes_pkg::t_disp_cmd disp_cmd;
    logic [7:0]          disp_q;

    logic          slot_free;
    logic          accept;
    logic [PW-1:0] rd_pos;
    logic [PW:0]   ref_sum;
    logic [PW-1:0] ref_phys;
    logic [PW-1:0] base_inc;
    logic [3:0]    idx_inc;
    logic          is_digit;

    assign slot_free = !r_ov || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;

    // Physical display address of the refresh position being read; it is held
    // while a refresh result waits for the output register.
    assign rd_pos   = (r_state == S_REF_OUT) ? r_prp : r_rp;
    assign ref_sum  = {1'b0, r_base} + {1'b0, rd_pos};
    assign ref_phys = (ref_sum >= NP_W) ? PW'(ref_sum - NP_W) : ref_sum[PW-1:0];
    assign base_inc = (r_base == LAST_POS) ? '0 : r_base + 1'b1;
    assign idx_inc  = (r_idx + 4'd1 == r_ring) ? 4'd0 : r_idx + 4'd1;
    assign is_digit = (r_key <= kdes_pkg::KEY_LAST_DIGIT) || (r_key == kdes_pkg::KEY_ZERO);
    assign st_raddr = (r_idx < r_count) ? r_idx[SW-1:0] : '0;

    // Sequencer and next-state logic.
    always_comb begin
        n_state    = r_state;
        n_entering = r_entering;
        n_scr_en   = r_scr_en;
        n_count    = r_count;
        n_ring     = r_ring;
        n_pos      = r_pos;
        n_back     = r_back;
        n_rp       = r_rp;
        n_prp      = r_prp;
        n_base     = r_base;
        n_i        = r_i;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_seg      = kdes_pkg::BLANK;
        n_sel      = 8'd0;
        emit       = 1'b0;
        st_we      = 1'b0;
        disp_cmd       = '0;
        disp_cmd.raddr = kdes_pkg::POS_W'(ref_phys);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == kdes_pkg::OP_SCROLL && r_scr_en && r_ring != 4'd0) begin
                    // Rebuild all positions from the ring, starting at base zero.
                    n_i     = '0;
                    n_idx   = r_pos;
                    n_base  = '0;
                    n_state = S_SCR_RD;
                end else if (r_op == kdes_pkg::OP_REFRESH) begin
                    n_prp   = r_rp;
                    n_rp    = (r_rp == LAST_POS) ? '0 : r_rp + 1'b1;
                    n_state = S_REF_OUT;
                end else if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == kdes_pkg::OP_KEY) begin
                        if (r_key == kdes_pkg::KEY_TOGGLE) begin
                            if (!r_entering) begin
                                n_entering   = 1'b1;
                                n_count      = 4'd0;
                                n_pos        = 4'd0;
                                n_scr_en     = 1'b0;
                                n_base       = '0;
                                disp_cmd.clr = 1'b1;
                            end else begin
                                n_entering = 1'b0;
                                n_ring     = r_count + 4'd2;
                                n_pos      = 4'd0;
                                n_scr_en   = 1'b1;
                            end
                        end else if (r_entering) begin
                            if (is_digit && r_count < 4'(MAX_DIGITS)) begin
                                // Append a digit; the display shifts left by moving its base.
                                st_we          = 1'b1;
                                n_count        = r_count + 4'd1;
                                disp_cmd.we    = 1'b1;
                                disp_cmd.waddr = kdes_pkg::POS_W'(r_base);
                                disp_cmd.wdata = kdes_pkg::seg_code(r_key);
                                n_base         = base_inc;
                            end
                        end else if (r_key == kdes_pkg::KEY_STAR) begin
                            n_back = !r_back;
                        end
                    end
                end
            end
            S_SCR_RD: begin
                n_hit   = (r_idx < r_count);
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                if (r_i != LAST_POS || slot_free) begin
                    disp_cmd.we    = 1'b1;
                    disp_cmd.waddr = kdes_pkg::POS_W'(r_i);
                    disp_cmd.wdata = r_hit ? kdes_pkg::seg_code(r_st_q) : kdes_pkg::BLANK;
                    if (r_i == LAST_POS) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (r_back) begin
                            n_pos = (r_pos == 4'd0) ? r_ring - 4'd1 : r_pos - 4'd1;
                        end else begin
                            n_pos = (r_pos + 4'd1 == r_ring) ? 4'd0 : r_pos + 4'd1;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_idx   = idx_inc;
                        n_state = S_SCR_RD;
                    end
                end
            end
            S_REF_OUT: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_seg   = disp_q;
                    n_sel   = 8'd1 << r_prp;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_entering <= 1'b0;
            r_scr_en   <= 1'b0;
            r_count    <= 4'd0;
            r_ring     <= 4'd0;
            r_pos      <= 4'd0;
            r_back     <= 1'b0;
            r_rp       <= '0;
            r_base     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_entering <= n_entering;
            r_scr_en   <= n_scr_en;
            r_count    <= n_count;
            r_ring     <= n_ring;
            r_pos      <= n_pos;
            r_back     <= n_back;
            r_rp       <= n_rp;
            r_base     <= n_base;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: captured transaction, scroll walk and result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_key <= i_key;
        end
        r_prp <= n_prp;
        r_i   <= n_i;
        r_idx <= n_idx;
        r_hit <= n_hit;
        if (emit) begin
            r_seg <= n_seg;
            r_sel <= n_sel;
        end
    end

    // Digit store: written on append, read one entry per scroll step.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[r_count[SW-1:0]] <= r_key;
        end
        r_st_q <= r_store[st_raddr];
    end

    kdes_disp #(
        .NUM_POSITIONS(NUM_POSITIONS)
    ) u_disp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (disp_cmd),
        .o_rdata (disp_q)
    );

    assign o_valid        = r_ov;
    assign o_segments     = r_seg;
    assign o_digit_select = r_sel;
    assign o_entry_mode   = r_entering;
    assign o_digit_count  = r_count;

endmodule

`default_nettype wire
